### rtl/rpn_pkg.sv
// Shared codes for the RPN stack evaluator: command kinds, status codes
// and iteration counts of the shift/add unit. No dependencies.
package rpn_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SUB     = 3'd2,
    KIND_MUL     = 3'd3,
    KIND_DIV     = 3'd4,
    KIND_MOD     = 3'd5,
    KIND_PRINT   = 3'd6,
    KIND_UNKNOWN = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ZDIV    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  localparam int unsigned CntW      = 6;
  localparam logic [CntW-1:0] MulSteps = 6'd32;
  localparam logic [CntW-1:0] DivSteps = 6'd48;
  localparam logic [CntW-1:0] ModSteps = 6'd16;

  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

endpackage

### rtl/rpn_stack_evaluator_core.sv
// RPN stack evaluator core, signed Q16.16 operands.
// Mul, div and mod are worked out by the single-bit shift/add/subtract loop.
// One word at a time: busy_o stays high until the strobe cycle ends, so a new word is
// accepted only once the previous word is done. The receiver cannot stall.
// Async active-low reset empties the stack at once; no clearing pass needed.
module rpn_stack_evaluator_core
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic signed [31:0] number_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic signed [31:0] shown_value_o,
  output logic        shown_valid_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_GOT,
    S_SETUP,
    S_ITER,
    S_FIN,
    S_PUSH,
    S_DONE
  } state_e;

  state_e          state_q;
  kind_e           kind_q;
  status_e         status_q;
  logic [LW-1:0]   level_q;
  logic            empty_q;    // last pop found the stack empty
  logic            left_q;     // second operand is being popped
  logic [CntW-1:0] cnt_q;
  logic [31:0]     shown_q;
  logic            shown_valid_q;

  logic [31:0] l_q, r_q, res_q, dsr_q;
  logic [32:0] rem_q;
  logic [47:0] quo_q;
  logic        neg_q;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_q;

  // ---- stack memory ----
  logic [LW-1:0] lvl_dec;
  logic [AW-1:0] raddr, waddr;
  logic          mem_we, stack_full;

  assign lvl_dec    = level_q - {{(LW-1){1'b0}}, 1'b1};
  assign raddr      = lvl_dec[AW-1:0];
  assign waddr      = level_q[AW-1:0];
  assign stack_full = (level_q >= LW'(STACK_DEPTH));
  assign mem_we     = (state_q == S_PUSH) && !stack_full;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= res_q;
    end
    rd_q <= mem[raddr];
  end

  // ---- popped value and operand magnitudes ----
  logic [31:0] pv;
  logic        pv_int_zero;
  logic [31:0] l_abs, r_abs;

  assign pv          = empty_q ? 32'd0 : rd_q;
  assign pv_int_zero = (pv[31:16] == 16'h0000) ||
                       ((pv[31:16] == 16'hFFFF) && (pv[15:0] != 16'h0000));
  assign l_abs = l_q[31] ? (~l_q + 32'd1) : l_q;
  assign r_abs = r_q[31] ? (~r_q + 32'd1) : r_q;

  // ---- shared adder/subtractor ----
  logic [33:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_SETUP: begin
        alu_a   = {{2{l_q[31]}}, l_q};
        alu_b   = {{2{r_q[31]}}, r_q};
        alu_sub = (kind_q == KIND_SUB);
      end
      S_ITER: begin
        if (kind_q == KIND_MUL) begin
          alu_a = {2'b00, rem_q[31:0]};
          alu_b = quo_q[0] ? {2'b00, dsr_q} : 34'd0;
        end else begin
          alu_a   = {1'b0, rem_q[31:0], quo_q[47]};
          alu_b   = {2'b00, dsr_q};
          alu_sub = 1'b1;
        end
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {33'd0, alu_sub};

  logic [31:0] addsub_sat;
  always_comb begin
    if (alu_sum[33:31] == 3'b000 || alu_sum[33:31] == 3'b111) begin
      addsub_sat = alu_sum[31:0];
    end else begin
      addsub_sat = alu_sum[33] ? QMin : QMax;
    end
  end

  // ---- final scaling and saturation ----
  logic [47:0] mag;
  logic [31:0] fin_val, mod_mag;

  assign mag     = (kind_q == KIND_MUL) ? {rem_q[31:0], quo_q[31:16]} : quo_q;
  assign mod_mag = {rem_q[15:0], 16'h0000};

  always_comb begin
    if (kind_q == KIND_MOD) begin
      fin_val = neg_q ? (~mod_mag + 32'd1) : mod_mag;
    end else if (!neg_q) begin
      fin_val = (|mag[47:31]) ? QMax : mag[31:0];
    end else if ((|mag[47:32]) || (mag[31] && (|mag[30:0]))) begin
      fin_val = QMin;
    end else begin
      fin_val = ~mag[31:0] + 32'd1;
    end
  end

  // ---- sequencer ----
  function automatic status_e raise(status_e cur, status_e s);
    return (cur == ST_OK) ? s : cur;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kind_q        <= KIND_PUSH;
      status_q      <= ST_OK;
      level_q       <= '0;
      empty_q       <= 1'b0;
      left_q        <= 1'b0;
      cnt_q         <= '0;
      shown_q       <= '0;
      shown_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            kind_q        <= kind_e'(kind_i);
            status_q      <= (kind_e'(kind_i) == KIND_UNKNOWN) ? ST_UNKNOWN : ST_OK;
            shown_q       <= '0;
            shown_valid_q <= 1'b0;
            left_q        <= 1'b0;
            case (kind_e'(kind_i))
              KIND_PUSH: state_q <= S_PUSH;
              KIND_UNKNOWN: begin
                state_q  <= S_DONE;
              end
              default: state_q <= S_RD;
            endcase
          end
        end
        S_RD: begin
          if (level_q != '0) begin
            level_q <= lvl_dec;
            empty_q <= 1'b0;
          end else begin
            empty_q  <= 1'b1;
            status_q <= raise(status_q, ST_EMPTY);
          end
          state_q <= S_GOT;
        end
        S_GOT: begin
          if (left_q) begin
            state_q <= S_SETUP;
          end else begin
            case (kind_q)
              KIND_PRINT: begin
                if (!empty_q) begin
                  shown_q       <= pv;
                  shown_valid_q <= 1'b1;
                end
                state_q <= S_DONE;
              end
              KIND_DIV: begin
                if (pv == 32'd0) begin
                  status_q <= raise(status_q, ST_ZDIV);
                  state_q  <= S_DONE;
                end else begin
                  left_q  <= 1'b1;
                  state_q <= S_RD;
                end
              end
              KIND_MOD: begin
                if (pv_int_zero) begin
                  status_q <= raise(status_q, ST_ZDIV);
                  state_q  <= S_DONE;
                end else begin
                  left_q  <= 1'b1;
                  state_q <= S_RD;
                end
              end
              default: begin
                left_q  <= 1'b1;
                state_q <= S_RD;
              end
            endcase
          end
        end
        S_SETUP: begin
          case (kind_q)
            KIND_MUL: begin
              cnt_q   <= MulSteps;
              state_q <= S_ITER;
            end
            KIND_DIV: begin
              cnt_q   <= DivSteps;
              state_q <= S_ITER;
            end
            KIND_MOD: begin
              cnt_q   <= ModSteps;
              state_q <= S_ITER;
            end
            default: state_q <= S_PUSH;
          endcase
        end
        S_ITER: begin
          cnt_q <= cnt_q - {{(CntW-1){1'b0}}, 1'b1};
          if (cnt_q == {{(CntW-1){1'b0}}, 1'b1}) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (stack_full) begin
            status_q <= raise(status_q, ST_FULL);
          end else begin
            level_q <= level_q + {{(LW-1){1'b0}}, 1'b1};
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i && !busy_o) begin
          res_q <= number_i;
        end
      end
      S_GOT: begin
        if (left_q) begin
          l_q <= pv;
        end else begin
          r_q <= pv;
        end
      end
      S_SETUP: begin
        rem_q <= '0;
        case (kind_q)
          KIND_MUL: begin
            quo_q <= {16'h0000, l_abs};
            dsr_q <= r_abs;
            neg_q <= l_q[31] ^ r_q[31];
          end
          KIND_DIV: begin
            quo_q <= {l_abs, 16'h0000};
            dsr_q <= r_abs;
            neg_q <= l_q[31] ^ r_q[31];
          end
          KIND_MOD: begin
            quo_q <= {l_abs[31:16], 32'h0000_0000};
            dsr_q <= {16'h0000, r_abs[31:16]};
            neg_q <= l_q[31];
          end
          default: begin
            res_q <= addsub_sat;
          end
        endcase
      end
      S_ITER: begin
        if (kind_q == KIND_MUL) begin
          rem_q        <= {1'b0, alu_sum[32:1]};
          quo_q[31:0]  <= {alu_sum[0], quo_q[31:1]};
        end else begin
          // restoring step: keep the difference unless it borrowed
          if (!alu_sum[33]) begin
            rem_q <= alu_sum[32:0];
          end else begin
            rem_q <= {rem_q[31:0], quo_q[47]};
          end
          quo_q <= {quo_q[46:0], ~alu_sum[33]};
        end
      end
      S_FIN: begin
        res_q <= fin_val;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign shown_value_o = shown_q;
  assign shown_valid_o = shown_valid_q;

endmodule
